/* hdl/dpc_pkg.sv */
`timescale 1ns / 1ps

package dpc_pkg;

   localparam int VALUE_W = 32;
   localparam int REST_W  = 32;
   localparam int REV_W   = 34;
   localparam int PROD_W  = 64;
   localparam int RECIP_SHIFT = 35;
   localparam logic [REST_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } dpc_cmd_type;

   typedef struct packed {
      logic rest_zero;
      logic match;
   } dpc_status_type;

endpackage

/* hdl/dpc_if.sv */
`timescale 1ns / 1ps

interface dpc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [dpc_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface dpc_rsp_if;
   logic valid;
   logic ready;
   logic is_palindrome;

   modport source (output valid, output is_palindrome, input ready);
   modport sink (input valid, input is_palindrome, output ready);
endinterface

/* hdl/dpc_dp.sv */
`timescale 1ns / 1ps

module dpc_dp (
   input  logic                                clock,
   input  logic signed [dpc_pkg::VALUE_W-1:0] value,
   input  dpc_pkg::dpc_cmd_type               cmd,
   output dpc_pkg::dpc_status_type            status,
   output logic                                is_palindrome
);

   logic [dpc_pkg::REST_W-1:0] mag_ff, mag_in;
   logic [dpc_pkg::REST_W-1:0] rest_ff, rest_in;
   logic [dpc_pkg::REV_W-1:0]  rev_ff, rev_in;
   logic                       out_ff, out_in;

   logic [dpc_pkg::REST_W-1:0] abs_value;
   logic [dpc_pkg::PROD_W-1:0] prod;
   logic [dpc_pkg::REST_W-1:0] quot;
   logic [dpc_pkg::REST_W-1:0] quot_ten;
   logic [3:0]                 digit;

   assign abs_value = value[dpc_pkg::VALUE_W-1] ? (~value + 32'd1) : value;

   // divide by ten through the reciprocal
   assign prod     = dpc_pkg::PROD_W'(rest_ff) * dpc_pkg::PROD_W'(dpc_pkg::RECIP_TEN);
   assign quot     = dpc_pkg::REST_W'(prod >> dpc_pkg::RECIP_SHIFT);
   assign quot_ten = (quot << 3) + (quot << 1);
   assign digit    = 4'(rest_ff - quot_ten);

   assign status.rest_zero = (rest_ff == '0);
   assign status.match     = (rest_ff == '0) && (rev_ff == dpc_pkg::REV_W'(mag_ff));

   always_comb begin
      mag_in  = mag_ff;
      rest_in = rest_ff;
      rev_in  = rev_ff;
      out_in  = out_ff;
      if (cmd.load) begin
         mag_in  = abs_value;
         rest_in = abs_value;
         rev_in  = '0;
      end else if (cmd.step) begin
         rest_in = quot;
         rev_in  = (rev_ff << 3) + (rev_ff << 1) + dpc_pkg::REV_W'(digit);
      end
      if (cmd.emit) begin
         out_in = status.match;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      rest_ff <= rest_in;
      rev_ff  <= rev_in;
      out_ff  <= out_in;
   end

   assign is_palindrome = out_ff;

endmodule

/* hdl/dpc_ctrl.sv */
`timescale 1ns / 1ps

module dpc_ctrl #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  dpc_pkg::dpc_status_type status,
   output dpc_pkg::dpc_cmd_type    cmd
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RUN  = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             done;
   logic             out_free;

   assign done     = status.rest_zero || (count_ff == CNT_MAX);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (done) begin
               if (out_free) begin
                  cmd.emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("digit count past limit");

   a_step_not_done: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !status.rest_zero && (count_ff != CNT_MAX))
      else $error("step after last digit");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("result lost");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result overwritten");

endmodule

/* hdl/decimal_palindrome_check_top.sv */
// A word is accepted only in idle; the datapath then peels off one decimal digit of |value|
// per cycle (none for zero, at most MAX_DIGITS) through the divide-by-ten loop, and the
// result is registered once the result register is free. The next word is accepted only
// after that result has been registered.
// Reset: synchronous, active high; clears the controller and the result valid.
`timescale 1ns / 1ps

module decimal_palindrome_check_top #(
   parameter int MAX_DIGITS = 10
) (
   input logic       clock,
   input logic       reset,
   dpc_req_if.sink   req_port,
   dpc_rsp_if.source rsp_port
);

   dpc_pkg::dpc_cmd_type    cmd;
   dpc_pkg::dpc_status_type status;

   dpc_ctrl #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   dpc_dp u_dp (
      .clock         (clock),
      .value         (req_port.value),
      .cmd           (cmd),
      .status        (status),
      .is_palindrome (rsp_port.is_palindrome)
   );

endmodule

/* sim/decimal_palindrome_check_top_tb.sv */
`timescale 1ns / 1ps

module decimal_palindrome_check_top_tb;

   localparam int MAX_DIGITS     = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct {
      logic [dpc_pkg::VALUE_W-1:0] value;
      logic                        flag;
   } pending_word_type;

   logic clock = 1'b0;
   logic reset;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches    = 0;

   pending_word_type pending_flags[$];

   dpc_req_if req_bus ();
   dpc_rsp_if rsp_bus ();

   decimal_palindrome_check_top #(
      .MAX_DIGITS(MAX_DIGITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus)
   );

   always #4 clock = ~clock;

   function automatic logic palindrome_of(input logic [dpc_pkg::VALUE_W-1:0] raw);
      logic [32:0] mag;
      logic [32:0] rest;
      logic [63:0] rev;
      int          n;
      mag  = raw[dpc_pkg::VALUE_W-1] ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
      rest = mag;
      rev  = 64'd0;
      for (n = 0; n < MAX_DIGITS && rest != 33'd0; n++) begin
         rev  = rev * 64'd10 + {31'd0, rest % 33'd10};
         rest = rest / 33'd10;
      end
      return (rest == 33'd0 && rev == {31'd0, mag});
   endfunction

   function automatic logic [dpc_pkg::VALUE_W-1:0] make_palindrome(input int digits);
      logic [63:0] num;
      int          d[10];
      int          k;
      for (k = 0; k < (digits + 1) / 2; k++) begin
         d[k]              = $urandom_range(9, (k == 0) ? 1 : 0);
         d[digits - 1 - k] = d[k];
      end
      num = 64'd0;
      for (k = 0; k < digits; k++) begin
         num = num * 64'd10 + 64'(d[k]);
      end
      if (num > 64'd2147483647) begin
         num = 64'd2147447412;
      end
      return num[dpc_pkg::VALUE_W-1:0];
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [dpc_pkg::VALUE_W-1:0] value,
                                  input logic got, input logic want);
      if (mismatches < 100) begin
         $display("mismatch: %s value=%0d got=%b want=%b", what, $signed(value), got, want);
      end
      mismatches++;
   endtask

   // Drop valid only when a gap is taken; hold it across back-to-back words.
   task automatic send_word(input logic [dpc_pkg::VALUE_W-1:0] v);
      if ($urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99, 0) < send_idle_pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
      pending_flags.push_back('{value: v, flag: palindrome_of(v)});
   endtask

   task automatic test_edge_values();
      logic [dpc_pkg::VALUE_W-1:0] edge_words[$];
      edge_words = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'd11, 32'd121,
                     -32'sd121, 32'h7FFF_FFFF, 32'h8000_0000, 32'd2147447412,
                     -32'sd2147447412, 32'd1234554321, 32'd1000000001, 32'd1000000000,
                     32'd12321, 32'd123, 32'h5555_5555, 32'hAAAA_AAAA, -32'sd8,
                     32'd1001, 32'd100, -32'sd1000000001, 32'd999999999};
      foreach (edge_words[i]) begin
         send_word(edge_words[i]);
      end
   endtask

   task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
      logic [dpc_pkg::VALUE_W-1:0] v;
      int                          pick;
      int                          digits;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         pick   = $urandom_range(99, 0);
         digits = $urandom_range(10, 1);
         if (pick < 40) begin
            v = make_palindrome(digits);
         end else if (pick < 55) begin
            v = make_palindrome(digits) + $urandom_range(9, 1);
         end else if (pick < 70) begin
            v = $urandom_range(9999, 0);
         end else begin
            v = $urandom;
         end
         if (pick < 70 && $urandom_range(1, 0) == 1) begin
            v = -v;
         end
         send_word(v);
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : check_results
      pending_word_type head;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_flags.size() == 0) begin
            report_mismatch("unexpected word", '0, rsp_bus.is_palindrome, 1'bx);
         end else begin
            head = pending_flags.pop_front();
            if (rsp_bus.is_palindrome !== head.flag) begin
               report_mismatch("is_palindrome", head.value, rsp_bus.is_palindrome,
                               head.flag);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_values();
      test_random_mix(270, 0, 0);
      test_random_mix(260, 67, 0);
      test_random_mix(260, 0, 67);
      test_random_mix(260, 16, 16);

      req_bus.valid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
